/* rtl/gcp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gcp_pkg: shared definitions for the gamma correction pixel pipeline
// Register codes, fixed-point constants, stage records and the elaboration
// time function that builds the exp2 coefficient table.
// ----------------------------------------------------------------------------
package gcp_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam int OUT_W      = 32;
  localparam int STEPS      = 24;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SRGB_MODE   = 3'd0,
    REG_EXPONENT    = 3'd1,
    REG_MAX_IN      = 3'd2,
    REG_MAX_OUT     = 3'd3,
    REG_INTEGER_OUT = 3'd4
  } cfg_reg_t;

  localparam logic [24:0] ONE_Q24     = 25'h100_0000;
  localparam logic [15:0] SRGB_KNEE   = 16'd52526;
  localparam logic [35:0] SRGB_OFFSET = 36'd922746880;  // 55 (0.055 scaled by 1000) in Q.24
  localparam logic [10:0] SRGB_MUL    = 11'd1055;
  localparam logic [8:0]  LIN_MUL     = 9'd323;         // 12.92 = 323 / 25
  localparam logic [31:0] RECIP_12    = 32'hAAAA_AAAB;  // 2^35 / 12, rounded up
  localparam logic [28:0] RECIP_125   = 29'h1062_4DD3;  // 2^35 / 125, rounded up
  localparam logic [27:0] RECIP_25    = 28'd171798692;  // 2^32 / 25, rounded up

  typedef struct packed {
    logic [16:0] rem;
    logic [23:0] q;
    logic        sat;
    logic        zero;
  } div_t;

  typedef struct packed {
    logic [24:0] f;
    logic [30:0] x;
    logic [4:0]  top;
    logic [23:0] frac;
  } log_t;

  typedef struct packed {
    logic [24:0] f;
    logic [20:0] lin;
    logic [32:0] y;
    logic [8:0]  whole;
    logic [23:0] part;
  } exp_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bt;
    res = '0;
    rem = v;
    bt  = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Factor 2^-(2^(idx-24)) in Q.32, by repeated square roots starting from 0.5.
  function automatic logic [31:0] exp_coef(input int idx);
    logic [63:0] c;
    c = 64'h8000_0000;
    for (int j = 23; j >= 0; j--) begin
      if (j >= idx) begin
        c = isqrt64({c[31:0], 32'h0});
      end
    end
    return c[31:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/gamma_correction_pixel.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gamma_correction_pixel: streaming sRGB / power-law gamma correction
// Normalizes each sample by max_in, applies the sRGB encode curve or a
// power law via -log2 and 2^-t, clips, scales by max_out, rounds if integer_out.
//
// Channel  Direction  Handshake          Payload
// in_      slave      tvalid / tready    tdata: sample_in
// out_     master     tvalid / tready    tdata: sample_out (Q16.FRACTION_BITS)
// cfg_     write      cfg_we             cfg_addr, cfg_wdata
//
// One item enters per clock while the pipeline is not held; an accepted item
// passes the 24-step divider, 24 squaring stages and 24 exp2 multiply stages
// before out_tvalid. Reset (rst_n low, synchronous) clears all valid bits and
// loads the register defaults. When out_tready is low with a result waiting,
// the whole pipeline holds and in_tready drops in the same cycle.
// ----------------------------------------------------------------------------
module gamma_correction_pixel #(
  parameter int SAMPLE_BITS   = gcp_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = gcp_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   in_tdata,   // [SAMPLE_BITS-1:0] sample_in
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [gcp_pkg::OUT_W-1:0]               out_tdata,  // [31:0] sample_out
  input  wire logic                               cfg_we,
  input  wire logic [gcp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [gcp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gcp_pkg::*;

  localparam int CW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam logic [40:0] HALF = 41'd1 << (FRACTION_BITS - 1);
  localparam logic [40:0] FMASK = (41'd1 << FRACTION_BITS) - 41'd1;

  // Configuration registers
  logic        srgb_mode_r;
  logic [19:0] exponent_r;
  logic [15:0] max_in_r;
  logic [15:0] max_out_r;
  logic        integer_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srgb_mode_r   <= 1'b0;
      exponent_r    <= 20'd65536;
      max_in_r      <= 16'd255;
      max_out_r     <= 16'd255;
      integer_out_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SRGB_MODE:   srgb_mode_r   <= cfg_wdata[0];
        REG_EXPONENT:    exponent_r    <= cfg_wdata[19:0];
        REG_MAX_IN:      max_in_r      <= cfg_wdata[15:0];
        REG_MAX_OUT:     max_out_r     <= cfg_wdata[15:0];
        REG_INTEGER_OUT: integer_out_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;

  assign adv        = !out_tvalid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------- Division: f = sample * 2^24 / max_in ----------------
  div_t             div_r   [0:STEPS];
  logic [STEPS:0]   div_v_r;
  logic [CW-1:0]    s_ext;
  logic [CW-1:0]    max_ext;
  div_t             div0_nxt;

  assign s_ext   = CW'(in_tdata[SAMPLE_BITS-1:0]);
  assign max_ext = CW'(max_in_r);

  always_comb begin
    div0_nxt.zero = (max_in_r == 16'd0);
    div0_nxt.sat  = (s_ext >= max_ext);
    div0_nxt.rem  = {1'b0, s_ext[15:0]};
    div0_nxt.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_v_r[0] <= 1'b0;
    end else if (adv) begin
      div_v_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0] <= div0_nxt;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_div
    logic [16:0] sh;
    logic        ge;
    div_t        d_nxt;
    always_comb begin
      sh          = {div_r[k].rem[15:0], 1'b0};
      ge          = (sh >= {1'b0, max_in_r});
      d_nxt       = div_r[k];
      d_nxt.rem   = ge ? (sh - {1'b0, max_in_r}) : sh;
      d_nxt.q     = {div_r[k].q[22:0], ge};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        div_v_r[k+1] <= div_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[k+1] <= d_nxt;
      end
    end
  end

  // ---------------- Normalize for log2 ----------------
  log_t           lg_r [0:STEPS];
  logic [STEPS:0] lg_v_r;
  log_t           nrm_nxt;
  logic [24:0]    f_div;

  always_comb begin
    if (div_r[STEPS].zero) begin
      f_div = '0;
    end else if (div_r[STEPS].sat) begin
      f_div = ONE_Q24;
    end else begin
      f_div = {1'b0, div_r[STEPS].q};
    end
    nrm_nxt.top = '0;
    for (int j = 0; j < 25; j++) begin
      if (f_div[j]) begin
        nrm_nxt.top = 5'(j);
      end
    end
    nrm_nxt.f    = f_div;
    nrm_nxt.x    = {6'd0, f_div} << (5'd30 - nrm_nxt.top);
    nrm_nxt.frac = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_v_r[0] <= 1'b0;
    end else if (adv) begin
      lg_v_r[0] <= div_v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lg_r[0] <= nrm_nxt;
    end
  end

  // One fraction bit of log2 per stage by squaring the mantissa.
  for (genvar k = 0; k < STEPS; k++) begin : g_log
    logic [61:0] sq;
    log_t        l_nxt;
    always_comb begin
      sq    = lg_r[k].x * lg_r[k].x;
      l_nxt = lg_r[k];
      if (sq[61]) begin
        l_nxt.x    = sq[61:31];
        l_nxt.frac = {lg_r[k].frac[22:0], 1'b1};
      end else begin
        l_nxt.x    = sq[60:30];
        l_nxt.frac = {lg_r[k].frac[22:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lg_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        lg_v_r[k+1] <= lg_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        lg_r[k+1] <= l_nxt;
      end
    end
  end

  // ---------------- n = -log2(f), then exponent products ----------------
  logic        n_v_r;
  logic [28:0] n_r;
  logic [24:0] n_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_v_r <= 1'b0;
    end else if (adv) begin
      n_v_r <= lg_v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r   <= {5'd24 - lg_r[STEPS].top, 24'd0} - {5'd0, lg_r[STEPS].frac};
      n_f_r <= lg_r[STEPS].f;
    end
  end

  logic        p_v_r;
  logic [48:0] pw_r;
  logic [30:0] n5_r;
  logic [24:0] lp_r;
  logic [24:0] p_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= n_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pw_r  <= exponent_r * n_r;
      n5_r  <= 31'(n_r) * 31'd5;
      lp_r  <= n_f_r[15:0] * LIN_MUL;
      p_f_r <= n_f_r;
    end
  end

  // ---------------- 2^-t, one bit of t per stage ----------------
  exp_t           ex_r [0:STEPS];
  logic [STEPS:0] ex_v_r;
  exp_t           ex0_nxt;
  logic [62:0]    t_srgb_p;
  logic [52:0]    lin_p;
  logic [32:0]    t_sel;

  always_comb begin
    t_srgb_p      = n5_r * RECIP_12;
    lin_p         = lp_r * RECIP_25;
    t_sel         = srgb_mode_r ? {5'd0, t_srgb_p[62:35]} : pw_r[48:16];
    ex0_nxt.f     = p_f_r;
    ex0_nxt.lin   = lin_p[52:32];
    ex0_nxt.y     = 33'h1_0000_0000;
    ex0_nxt.whole = t_sel[32:24];
    ex0_nxt.part  = t_sel[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r[0] <= 1'b0;
    end else if (adv) begin
      ex_v_r[0] <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_r[0] <= ex0_nxt;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_exp
    localparam logic [31:0] COEF = exp_coef(STEPS - 1 - k);
    logic [64:0] prod;
    exp_t        e_nxt;
    always_comb begin
      prod  = ex_r[k].y * COEF;
      e_nxt = ex_r[k];
      if (ex_r[k].part[STEPS-1-k]) begin
        e_nxt.y = prod[64:32];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ex_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        ex_v_r[k+1] <= ex_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ex_r[k+1] <= e_nxt;
      end
    end
  end

  // ---------------- Integer shift of 2^-t ----------------
  logic        y_v_r;
  logic [24:0] y_r;
  logic [20:0] y_lin_r;
  logic [24:0] y_f_r;
  logic [32:0] y_sh;

  assign y_sh = ex_r[STEPS].y >> ex_r[STEPS].whole[5:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_v_r <= 1'b0;
    end else if (adv) begin
      y_v_r <= ex_v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y_r     <= (ex_r[STEPS].whole >= 9'd33) ? 25'd0 : y_sh[32:8];
      y_lin_r <= ex_r[STEPS].lin;
      y_f_r   <= ex_r[STEPS].f;
    end
  end

  // ---------------- sRGB upper segment: (1.055 y - 0.055) ----------------
  logic        u_v_r;
  logic [31:0] d8_r;
  logic [24:0] u_y_r;
  logic [20:0] u_lin_r;
  logic [24:0] u_f_r;
  logic [35:0] a_mul;
  logic [35:0] a_diff;

  assign a_mul  = y_r * SRGB_MUL;
  assign a_diff = a_mul - SRGB_OFFSET;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_v_r <= 1'b0;
    end else if (adv) begin
      u_v_r <= y_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d8_r    <= (a_mul > SRGB_OFFSET) ? a_diff[34:3] : 32'd0;
      u_y_r   <= y_r;
      u_lin_r <= y_lin_r;
      u_f_r   <= y_f_r;
    end
  end

  // Division by 1000 as a shift by 3 and a reciprocal multiply by 1/125.
  logic        q_v_r;
  logic [25:0] upper_r;
  logic [24:0] q_y_r;
  logic [20:0] q_lin_r;
  logic [24:0] q_f_r;
  logic [60:0] up_p;

  assign up_p = d8_r * RECIP_125;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else if (adv) begin
      q_v_r <= u_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      upper_r <= up_p[60:35];
      q_y_r   <= u_y_r;
      q_lin_r <= u_lin_r;
      q_f_r   <= u_f_r;
    end
  end

  // ---------------- Curve select and clip ----------------
  logic        c_v_r;
  logic [24:0] c_r;
  logic [25:0] c_sel;

  always_comb begin
    if (srgb_mode_r) begin
      if (q_f_r <= {9'd0, SRGB_KNEE}) begin
        c_sel = {5'd0, q_lin_r};
      end else begin
        c_sel = upper_r;
      end
    end else if (exponent_r == 20'd0) begin
      c_sel = {1'b0, ONE_Q24};
    end else if (q_f_r == 25'd0) begin
      c_sel = '0;
    end else begin
      c_sel = {1'b0, q_y_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= q_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r <= (c_sel > {1'b0, ONE_Q24}) ? ONE_Q24 : c_sel[24:0];
    end
  end

  // ---------------- Scale, and round if integer output ----------------
  logic        m_v_r;
  logic [40:0] m_r;
  logic [40:0] m_prod;

  assign m_prod = c_r * max_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r <= m_prod >> (24 - FRACTION_BITS);
    end
  end

  logic [40:0] rnd_nxt;

  always_comb begin
    if (integer_out_r) begin
      rnd_nxt = (m_r + HALF) & ~FMASK;
    end else begin
      rnd_nxt = m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= rnd_nxt[OUT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  // The squaring stages keep the mantissa normalized in [1, 2).
  a_log_norm: assert property (@(posedge clk) disable iff (!rst_n)
    lg_v_r[STEPS] && (lg_r[STEPS].f != 25'd0) |-> lg_r[STEPS].x[30])
    else $error("log2 mantissa lost normalization");

  // After the integer shift, 2^-t never exceeds 1.0.
  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    y_v_r |-> (y_r <= ONE_Q24))
    else $error("exp2 result above one");

  // Rounded integer output carries no fraction bits.
  a_int_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && integer_out_r |-> (out_tdata_r[FRACTION_BITS-1:0] == '0))
    else $error("fraction bits set on integer output");
`endif

endmodule
`default_nettype wire
